FILE: rtl/bfhp_pkg.sv
// Shared types and constants for the bitstream file header parser.
// No dependencies; imported by the interfaces, the top level and the checker.
package bfhp_pkg;

	localparam int unsigned POS_W        = 19;
	localparam int unsigned LEN_W        = 16;
	localparam int unsigned PLEN_W       = 32;
	localparam int unsigned NUM_SECT     = 4;
	localparam int unsigned PREAMBLE_LEN = 13;
	localparam logic [7:0]  TAG_BASE     = 8'h61;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_PREAMBLE = 2'd1,
		STAT_TAG      = 2'd2,
		STAT_EARLY    = 2'd3
	} status_t;

	typedef struct packed {
		status_t           status;
		logic [POS_W-1:0]  design_name_offset;
		logic [LEN_W-1:0]  design_name_len;
		logic [POS_W-1:0]  part_name_offset;
		logic [LEN_W-1:0]  part_name_len;
		logic [POS_W-1:0]  date_offset;
		logic [LEN_W-1:0]  date_len;
		logic [POS_W-1:0]  time_offset;
		logic [LEN_W-1:0]  time_len;
		logic [POS_W-1:0]  payload_offset;
		logic [PLEN_W-1:0] payload_len;
	} result_t;

	// Fixed file preamble: 00 09 0F F0 0F F0 0F F0 0F F0 00 00 01
	function automatic logic [7:0] preamble_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'h00;
			4'd1:    b = 8'h09;
			4'd2:    b = 8'h0f;
			4'd3:    b = 8'hf0;
			4'd4:    b = 8'h0f;
			4'd5:    b = 8'hf0;
			4'd6:    b = 8'h0f;
			4'd7:    b = 8'hf0;
			4'd8:    b = 8'h0f;
			4'd9:    b = 8'hf0;
			4'd10:   b = 8'h00;
			4'd11:   b = 8'h00;
			4'd12:   b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/bfhp_byte_if.sv
// Byte stream channel: valid/ready handshake with one file byte per beat.
// Depends on bfhp_pkg.
interface bfhp_byte_if import bfhp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/bfhp_result_if.sv
// Result channel: valid/ready handshake with one parse result per beat.
// Depends on bfhp_pkg.
interface bfhp_result_if import bfhp_pkg::*; ();
	logic              valid;
	logic              ready;
	status_t           status;
	logic [POS_W-1:0]  design_name_offset;
	logic [LEN_W-1:0]  design_name_len;
	logic [POS_W-1:0]  part_name_offset;
	logic [LEN_W-1:0]  part_name_len;
	logic [POS_W-1:0]  date_offset;
	logic [LEN_W-1:0]  date_len;
	logic [POS_W-1:0]  time_offset;
	logic [LEN_W-1:0]  time_len;
	logic [POS_W-1:0]  payload_offset;
	logic [PLEN_W-1:0] payload_len;

	modport source (output valid, output status,
		output design_name_offset, output design_name_len,
		output part_name_offset, output part_name_len,
		output date_offset, output date_len,
		output time_offset, output time_len,
		output payload_offset, output payload_len,
		input ready);
	modport sink (input valid, input status,
		input design_name_offset, input design_name_len,
		input part_name_offset, input part_name_len,
		input date_offset, input date_len,
		input time_offset, input time_len,
		input payload_offset, input payload_len,
		output ready);
endinterface

FILE: rtl/bitstream_file_header_parser_top.sv
// Bitstream file header parser: checks the preamble, walks the tagged sections
// and reports offsets and lengths. Depends on bfhp_pkg, bfhp_byte_if, bfhp_result_if.
//
//  channel | dir | payload                                  | beat
//  bytes   | in  | data_byte, last_byte                     | one file byte
//  result  | out | status, section offsets/lengths, payload | one parse result
//
// One byte per cycle: each beat updates phase and counters in the cycle it is
// accepted, and any result lands in the output register at the same edge.
// The output register sets the rate: bytes stall only while a result waits.
// Reset clears parser state and the result register; parsing starts at the preamble.
// After a result, bytes are dropped until the one flagged last.
module bitstream_file_header_parser_top import bfhp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	bfhp_byte_if.sink     bytes,
	bfhp_result_if.source result
);

	typedef enum logic [3:0] {
		PH_PRE   = 4'd0,
		PH_TAG0  = 4'd1,
		PH_TAG1  = 4'd2,
		PH_TAG2  = 4'd3,
		PH_TAG3  = 4'd4,
		PH_TAG4  = 4'd5,
		PH_LEN0  = 4'd6,
		PH_LEN1  = 4'd7,
		PH_LEN2  = 4'd8,
		PH_LEN3  = 4'd9,
		PH_SKIP0 = 4'd10,
		PH_SKIP1 = 4'd11,
		PH_SKIP2 = 4'd12,
		PH_SKIP3 = 4'd13,
		PH_LEN32 = 4'd14
	} phase_t;

	phase_t            phase_q, phase_n;
	logic [LEN_W-1:0]  cnt_q, cnt_n;
	logic [POS_W-1:0]  pos_q, pos_n, pos_inc;
	logic [PLEN_W-1:0] acc_q, acc_n;
	logic [POS_W-1:0]  offs_q [NUM_SECT+1];
	logic [POS_W-1:0]  offs_n [NUM_SECT+1];
	logic [LEN_W-1:0]  lens_q [NUM_SECT];
	logic [LEN_W-1:0]  lens_n [NUM_SECT];
	logic              fin_q, fin_n;
	logic              hit;
	status_t           stat;
	result_t           res_n, res_q;
	logic              res_valid_q;
	logic              take;
	logic [2:0]        tag_idx;
	logic [1:0]        sect_idx;
	logic [LEN_W-1:0]  len16;

	assign bytes.ready = !res_valid_q || result.ready;
	assign take        = bytes.valid && bytes.ready;
	assign pos_inc     = pos_q + 1'b1;
	assign tag_idx     = 3'(phase_q - PH_TAG0);
	assign len16       = {acc_q[7:0], bytes.data_byte};

	always_comb begin
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		pos_n    = pos_q;
		acc_n    = acc_q;
		offs_n   = offs_q;
		lens_n   = lens_q;
		fin_n    = fin_q;
		hit      = 1'b0;
		stat     = STAT_OK;
		sect_idx = '0;
		res_n    = res_q;

		if (!fin_q) begin
			pos_n = pos_inc;
			unique case (phase_q) inside
				PH_PRE: begin
					if (cnt_q >= LEN_W'(PREAMBLE_LEN) ||
						bytes.data_byte != preamble_byte(cnt_q[3:0])) begin
						hit  = 1'b1;
						stat = STAT_PREAMBLE;
					end else if (cnt_q + 1'b1 == LEN_W'(PREAMBLE_LEN)) begin
						phase_n = PH_TAG0;
						cnt_n   = '0;
					end else begin
						cnt_n = cnt_q + 1'b1;
					end
				end
				[PH_TAG0:PH_TAG4]: begin
					if (bytes.data_byte != TAG_BASE + 8'(tag_idx)) begin
						hit  = 1'b1;
						stat = STAT_TAG;
					end else begin
						cnt_n   = '0;
						acc_n   = '0;
						phase_n = (phase_q == PH_TAG4) ? PH_LEN32
							: phase_t'(4'(PH_LEN0) + 4'(tag_idx));
					end
				end
				[PH_LEN0:PH_LEN3]: begin
					sect_idx = 2'(phase_q - PH_LEN0);
					acc_n    = PLEN_W'(len16);
					cnt_n    = cnt_q + 1'b1;
					if (cnt_q != '0) begin
						// second length byte: record the section
						offs_n[3'(sect_idx)] = pos_inc;
						lens_n[sect_idx]     = len16;
						cnt_n                = len16;
						phase_n = (len16 == '0)
							? phase_t'(4'(PH_TAG1) + 4'(sect_idx))
							: phase_t'(4'(PH_SKIP0) + 4'(sect_idx));
					end
				end
				[PH_SKIP0:PH_SKIP3]: begin
					sect_idx = 2'(phase_q - PH_SKIP0);
					if (cnt_q != '0)
						cnt_n = cnt_q - 1'b1;
					if (cnt_q <= LEN_W'(1))
						phase_n = phase_t'(4'(PH_TAG1) + 4'(sect_idx));
				end
				PH_LEN32: begin
					acc_n = {acc_q[PLEN_W-9:0], bytes.data_byte};
					cnt_n = cnt_q + 1'b1;
					if (cnt_q >= LEN_W'(3)) begin
						offs_n[NUM_SECT] = pos_inc;
						hit              = 1'b1;
						stat             = STAT_OK;
					end
				end
				default: begin
					phase_n = PH_PRE;
					cnt_n   = '0;
				end
			endcase

			if (!hit && bytes.last_byte) begin
				hit  = 1'b1;
				stat = STAT_EARLY;
			end

			if (hit) begin
				res_n.status             = stat;
				res_n.design_name_offset = offs_n[0];
				res_n.design_name_len    = lens_n[0];
				res_n.part_name_offset   = offs_n[1];
				res_n.part_name_len      = lens_n[1];
				res_n.date_offset        = offs_n[2];
				res_n.date_len           = lens_n[2];
				res_n.time_offset        = offs_n[3];
				res_n.time_len           = lens_n[3];
				res_n.payload_offset     = (stat == STAT_OK) ? offs_n[NUM_SECT] : '0;
				res_n.payload_len        = (stat == STAT_OK) ? acc_n : '0;
				fin_n                    = 1'b1;
			end
		end

		// last byte of a file: restart for the next one
		if (bytes.last_byte && (fin_q || hit)) begin
			phase_n = PH_PRE;
			cnt_n   = '0;
			pos_n   = '0;
			acc_n   = '0;
			fin_n   = 1'b0;
			for (int i = 0; i <= NUM_SECT; i++)
				offs_n[i] = '0;
			for (int i = 0; i < NUM_SECT; i++)
				lens_n[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PRE;
			cnt_q       <= '0;
			pos_q       <= '0;
			acc_q       <= '0;
			fin_q       <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			for (int i = 0; i <= NUM_SECT; i++)
				offs_q[i] <= '0;
			for (int i = 0; i < NUM_SECT; i++)
				lens_q[i] <= '0;
		end else begin
			if (take) begin
				phase_q <= phase_n;
				cnt_q   <= cnt_n;
				pos_q   <= pos_n;
				acc_q   <= acc_n;
				fin_q   <= fin_n;
				offs_q  <= offs_n;
				lens_q  <= lens_n;
			end
			if (take && hit) begin
				res_valid_q <= 1'b1;
				res_q       <= res_n;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid              = res_valid_q;
	assign result.status             = res_q.status;
	assign result.design_name_offset = res_q.design_name_offset;
	assign result.design_name_len    = res_q.design_name_len;
	assign result.part_name_offset   = res_q.part_name_offset;
	assign result.part_name_len      = res_q.part_name_len;
	assign result.date_offset        = res_q.date_offset;
	assign result.date_len           = res_q.date_len;
	assign result.time_offset        = res_q.time_offset;
	assign result.time_len           = res_q.time_len;
	assign result.payload_offset     = res_q.payload_offset;
	assign result.payload_len        = res_q.payload_len;

endmodule

FILE: rtl/bfhp_checker.sv
// Port-level checks for the bitstream file header parser, bound to the top level.
// Depends on bfhp_pkg and bitstream_file_header_parser_top.
module bfhp_checker import bfhp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input status_t           status,
	input logic [POS_W-1:0]  design_name_offset,
	input logic [LEN_W-1:0]  design_name_len,
	input logic [LEN_W-1:0]  time_len,
	input logic [POS_W-1:0]  payload_offset,
	input logic [PLEN_W-1:0] payload_len
);

	// a waiting result must hold until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(payload_len))
		else $error("result dropped or changed while stalled");

	// bytes flow unless a result is stuck in the output register
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("byte ready does not follow output register state");

	// payload fields are only reported for a complete header
	a_err_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> payload_offset == '0 && payload_len == '0)
		else $error("payload fields nonzero on error result");

	// a preamble error happens before any section is recorded
	a_pre_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_PREAMBLE |->
			design_name_offset == '0 && design_name_len == '0 && time_len == '0)
		else $error("section fields set on preamble error");

endmodule

bind bitstream_file_header_parser_top bfhp_checker u_bfhp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_ready           (bytes.ready),
	.out_valid          (result.valid),
	.out_ready          (result.ready),
	.status             (result.status),
	.design_name_offset (result.design_name_offset),
	.design_name_len    (result.design_name_len),
	.time_len           (result.time_len),
	.payload_offset     (result.payload_offset),
	.payload_len        (result.payload_len)
);
